@@ sv/smsb_pkg.sv @@
// Shared types, constants and codes for the shared multi-stack buffer.
`default_nettype none

package smsb_pkg;

    localparam int NUM_STACKS_DEF = 4;
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_W         = 32;
    localparam int STACK_NUM_W    = 3;
    localparam int STATUS_W       = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_BAD   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_ENTRY
    } state_t;

endpackage

`default_nettype wire

@@ sv/smsb_entry_mem.sv @@
// Entry memory holding data and link words, with lazily built initial free chain.
`default_nettype none

module smsb_entry_mem #(
    parameter int CAPACITY = 64,
    parameter int IDX_W    = 6,
    parameter int LINK_W   = 7
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [IDX_W-1:0]          rd_addr,
    output logic [smsb_pkg::DATA_W-1:0]    rd_data,
    output logic [LINK_W-1:0]              rd_link,
    input  wire logic                      wr_en,
    input  wire logic [IDX_W-1:0]          wr_addr,
    input  wire logic [smsb_pkg::DATA_W-1:0] wr_data,
    input  wire logic [LINK_W-1:0]         wr_link
);
    import smsb_pkg::*;

    localparam int WORD_W = DATA_W + LINK_W;

    logic [WORD_W-1:0] mem [CAPACITY];
    logic [WORD_W-1:0] rd_word_reg;
    logic              fresh_reg;
    logic [LINK_W-1:0] fresh_link_reg;
    logic [LINK_W-1:0] fill_reg;
    logic [LINK_W-1:0] fill_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_data, wr_link};
        end
        if (rd_en)
        begin
            rd_word_reg    <= mem[rd_addr];
            fresh_link_reg <= LINK_W'(rd_addr) + LINK_W'(1);
        end
    end

    // Entries at or above the fill count have never been written; their link reads as the next index.
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (LINK_W'(wr_addr) >= fill_reg))
        begin
            fill_next = LINK_W'(wr_addr) + LINK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (rd_en)
            begin
                fresh_reg <= (LINK_W'(rd_addr) >= fill_reg);
            end
        end
    end

    assign rd_data = rd_word_reg[WORD_W-1:LINK_W];
    assign rd_link = fresh_reg ? fresh_link_reg : rd_word_reg[LINK_W-1:0];

endmodule

`default_nettype wire

@@ sv/smsb_head_mem.sv @@
// Stack top table with per-stack valid bits so empty stacks read as null.
`default_nettype none

module smsb_head_mem #(
    parameter int NUM_STACKS = 4,
    parameter int STK_W      = 2,
    parameter int LINK_W     = 7,
    parameter int CAPACITY   = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [STK_W-1:0]  rd_addr,
    output logic [LINK_W-1:0]      rd_head,
    input  wire logic              wr_en,
    input  wire logic [STK_W-1:0]  wr_addr,
    input  wire logic [LINK_W-1:0] wr_head
);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

    logic [LINK_W-1:0]     mem [NUM_STACKS];
    logic [LINK_W-1:0]     rd_head_reg;
    logic                  rd_valid_reg;
    logic [NUM_STACKS-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_head;
        end
        if (rd_en)
        begin
            rd_head_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_head = rd_valid_reg ? rd_head_reg : NULL_LINK;

endmodule

`default_nettype wire

@@ sv/shared_multi_stack_buffer.sv @@
// Top level of the shared multi-stack buffer: handshake, sequencer and free list.
`default_nettype none

// Several LIFO stacks share one entry memory; free entries form a linked free
// list. One transaction is processed at a time. A push or pop that succeeds
// passes through these steps: stack top table read at acceptance, then a
// dependent entry memory read, then commit of link, top and free head. Its
// response is loaded with the commit. A bad stack number, full or empty
// answer ends in the stack top step, where its response is loaded.
// The steps follow from the registered reads of the two memories. The
// next request is accepted while a finished result still waits on the
// response channel. That request then holds in its last step until the
// waiting result is taken.
// No clearing pass runs after reset: a fill count supplies the initial free
// chain, so requests are accepted straight after reset.
module shared_multi_stack_buffer #(
    parameter int NUM_STACKS = smsb_pkg::NUM_STACKS_DEF,
    parameter int CAPACITY   = smsb_pkg::CAPACITY_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire logic                               op,
    input  wire logic [smsb_pkg::STACK_NUM_W-1:0]   stack_number,
    input  wire logic signed [smsb_pkg::DATA_W-1:0] push_value,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    output logic [smsb_pkg::STATUS_W-1:0]           status,
    output logic signed [smsb_pkg::DATA_W-1:0]      pop_value
);
    import smsb_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int LINK_W = $clog2(CAPACITY + 1);
    localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int SXT_W  = (STK_W > STACK_NUM_W) ? STK_W : STACK_NUM_W;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

    state_t                state_reg;
    state_t                state_next;
    logic                  op_reg;
    logic                  bad_reg;
    logic [STK_W-1:0]      stk_reg;
    logic [DATA_W-1:0]     value_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [LINK_W-1:0]     free_head_reg;
    logic [LINK_W-1:0]     free_head_next;
    logic                  rsp_valid_reg;
    status_t               status_reg;
    status_t               status_next;
    logic [DATA_W-1:0]     pop_value_reg;
    logic [DATA_W-1:0]     pop_value_next;

    logic                  accept;
    logic                  req_bad;
    logic [SXT_W-1:0]      stk_ext;
    logic [STK_W-1:0]      stk_in;
    logic                  slot_free;
    logic [LINK_W-1:0]     head;
    logic [LINK_W-1:0]     cand;
    logic                  cand_null;
    logic                  head_rd_en;
    logic                  entry_rd_en;
    logic                  rsp_load;
    logic                  commit;
    logic [DATA_W-1:0]     entry_data;
    logic [LINK_W-1:0]     entry_link;
    logic [DATA_W-1:0]     entry_wr_data;
    logic [LINK_W-1:0]     entry_wr_link;
    logic [LINK_W-1:0]     head_wr;

    assign accept    = req_valid && req_ready;
    assign stk_ext   = SXT_W'(stack_number) - SXT_W'(1);
    assign stk_in    = stk_ext[STK_W-1:0];
    assign req_bad   = (stack_number == '0) || (32'(stack_number) > 32'(NUM_STACKS));
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign cand      = (op_reg == OP_PUSH) ? free_head_reg : head;
    assign cand_null = (cand == NULL_LINK);

    smsb_head_mem #(
        .NUM_STACKS (NUM_STACKS),
        .STK_W      (STK_W),
        .LINK_W     (LINK_W),
        .CAPACITY   (CAPACITY)
    ) u_head_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (head_rd_en),
        .rd_addr (stk_in),
        .rd_head (head),
        .wr_en   (commit),
        .wr_addr (stk_reg),
        .wr_head (head_wr)
    );

    smsb_entry_mem #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .LINK_W   (LINK_W)
    ) u_entry_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (entry_rd_en),
        .rd_addr (cand[IDX_W-1:0]),
        .rd_data (entry_data),
        .rd_link (entry_link),
        .wr_en   (commit),
        .wr_addr (idx_reg),
        .wr_data (entry_wr_data),
        .wr_link (entry_wr_link)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                if (bad_reg || cand_null)
                begin
                    if (slot_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_ENTRY;
                end
            end
            ST_ENTRY:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        head_rd_en     = 1'b0;
        entry_rd_en    = 1'b0;
        rsp_load       = 1'b0;
        commit         = 1'b0;
        status_next    = STATUS_OK;
        pop_value_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                head_rd_en = req_valid && !req_bad;
            end
            ST_HEAD:
            begin
                if (bad_reg)
                begin
                    rsp_load    = slot_free;
                    status_next = STATUS_BAD;
                end
                else if (cand_null)
                begin
                    rsp_load    = slot_free;
                    status_next = (op_reg == OP_PUSH) ? STATUS_FULL : STATUS_EMPTY;
                end
                else
                begin
                    entry_rd_en = 1'b1;
                end
            end
            ST_ENTRY:
            begin
                rsp_load = slot_free;
                commit   = slot_free;
                if (op_reg == OP_POP)
                begin
                    pop_value_next = entry_data;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Push links the new entry to the old top; pop hands the entry back to the free list.
    always_comb
    begin
        if (op_reg == OP_PUSH)
        begin
            entry_wr_data  = value_reg;
            entry_wr_link  = head;
            head_wr        = LINK_W'(idx_reg);
            free_head_next = entry_link;
        end
        else
        begin
            entry_wr_data  = entry_data;
            entry_wr_link  = free_head_reg;
            head_wr        = entry_link;
            free_head_next = LINK_W'(idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_PUSH;
            bad_reg       <= 1'b0;
            stk_reg       <= '0;
            free_head_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                op_reg  <= op;
                bad_reg <= req_bad;
                stk_reg <= stk_in;
            end
            if (commit)
            begin
                free_head_reg <= free_head_next;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= push_value;
        end
        if (entry_rd_en)
        begin
            idx_reg <= cand[IDX_W-1:0];
        end
        if (rsp_load)
        begin
            status_reg    <= status_next;
            pop_value_reg <= pop_value_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign pop_value = pop_value_reg;

endmodule

`default_nettype wire
